[src/psd_pkg.sv]
package psd_pkg;

  localparam int COORD_W    = 32;
  localparam int DIFF_W     = 33;   // difference of two coordinates
  localparam int PROD_W     = 66;   // product of two differences
  localparam int SUM_W      = 68;   // sum of three products, signed
  localparam int CROSS_W    = 65;   // magnitude of one cross component
  localparam int SQ_W       = 130;  // square of one cross component
  localparam int NUM_W      = 132;  // dividend of the distance ratio
  localparam int DEN_W      = 66;   // divisor of the distance ratio
  localparam int QUO_W      = 66;   // squared distance, integer part
  localparam int ROOT_W     = 33;   // distance root
  localparam int REM_W      = 35;   // root remainder
  localparam int DIST_W     = 34;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;

  typedef enum logic [1:0] {
    REGION_DEGEN    = 2'd0,
    REGION_INTERIOR = 2'd1,
    REGION_START    = 2'd2,
    REGION_END      = 2'd3
  } psd_region_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_y;
    logic signed [COORD_W-1:0] query_z;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } psd_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        region;
  } psd_rsp_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    psd_region_t      region;
  } psd_frac_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    psd_region_t      region;
  } psd_quo_t;

endpackage

[src/psd_front.sv]
module psd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  psd_pkg::psd_req_t  req,
  input  logic [31:0]        deg_len,
  output logic               out_valid,
  output psd_pkg::psd_frac_t frac
);
  import psd_pkg::*;

  function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] a);
    return {a[COORD_W-1], a};
  endfunction

  // stage 1: differences and squared threshold
  logic                     s1_valid;
  logic signed [DIFF_W-1:0] s1_d [3];
  logic signed [DIFF_W-1:0] s1_v [3];
  logic signed [DIFF_W-1:0] s1_w [3];
  logic [2*COORD_W-1:0]     s1_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_d[0] <= sx(req.end_x) - sx(req.start_x);
      s1_d[1] <= sx(req.end_y) - sx(req.start_y);
      s1_d[2] <= sx(req.end_z) - sx(req.start_z);
      s1_v[0] <= sx(req.query_x) - sx(req.start_x);
      s1_v[1] <= sx(req.query_y) - sx(req.start_y);
      s1_v[2] <= sx(req.query_z) - sx(req.start_z);
      s1_w[0] <= sx(req.query_x) - sx(req.end_x);
      s1_w[1] <= sx(req.query_y) - sx(req.end_y);
      s1_w[2] <= sx(req.query_z) - sx(req.end_z);
      s1_t2   <= deg_len * deg_len;
    end
  end

  // stage 2: products
  logic                     s2_valid;
  logic signed [PROD_W-1:0] s2_dd [3];
  logic signed [PROD_W-1:0] s2_dv [3];
  logic signed [PROD_W-1:0] s2_dw [3];
  logic signed [PROD_W-1:0] s2_vv [3];
  logic signed [PROD_W-1:0] s2_ww [3];
  logic signed [PROD_W-1:0] s2_cp [6];
  logic [2*COORD_W-1:0]     s2_t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_dd[i] <= s1_d[i] * s1_d[i];
        s2_dv[i] <= s1_d[i] * s1_v[i];
        s2_dw[i] <= s1_d[i] * s1_w[i];
        s2_vv[i] <= s1_v[i] * s1_v[i];
        s2_ww[i] <= s1_w[i] * s1_w[i];
      end
      s2_cp[0] <= s1_d[1] * s1_v[2];
      s2_cp[1] <= s1_d[2] * s1_v[1];
      s2_cp[2] <= s1_d[2] * s1_v[0];
      s2_cp[3] <= s1_d[0] * s1_v[2];
      s2_cp[4] <= s1_d[0] * s1_v[1];
      s2_cp[5] <= s1_d[1] * s1_v[0];
      s2_t2    <= s1_t2;
    end
  end

  // stage 3: dot products, cross magnitudes, region decision
  logic signed [SUM_W-1:0]   len2_s, dot1_s, dot2_s, vv_s, ww_s;
  logic signed [CROSS_W+1:0] cd [3];
  logic [CROSS_W-1:0]        cmag [3];
  logic                      degen, pos1, pos2;
  psd_region_t               region_c;

  always_comb begin
    len2_s = SUM_W'(s2_dd[0]) + SUM_W'(s2_dd[1]) + SUM_W'(s2_dd[2]);
    dot1_s = SUM_W'(s2_dv[0]) + SUM_W'(s2_dv[1]) + SUM_W'(s2_dv[2]);
    dot2_s = -(SUM_W'(s2_dw[0]) + SUM_W'(s2_dw[1]) + SUM_W'(s2_dw[2]));
    vv_s   = SUM_W'(s2_vv[0]) + SUM_W'(s2_vv[1]) + SUM_W'(s2_vv[2]);
    ww_s   = SUM_W'(s2_ww[0]) + SUM_W'(s2_ww[1]) + SUM_W'(s2_ww[2]);
    for (int i = 0; i < 3; i++) begin
      cd[i]   = (CROSS_W+2)'(s2_cp[2*i]) - (CROSS_W+2)'(s2_cp[2*i+1]);
      cmag[i] = cd[i][CROSS_W+1] ? CROSS_W'(-cd[i]) : CROSS_W'(cd[i]);
    end
    degen = len2_s[DEN_W-1:0] < {2'b00, s2_t2};
    pos1  = !dot1_s[SUM_W-1] && (dot1_s != '0);
    pos2  = !dot2_s[SUM_W-1] && (dot2_s != '0);
    if (degen) begin
      region_c = REGION_DEGEN;
    end else if (pos1 && pos2) begin
      region_c = REGION_INTERIOR;
    end else if (!pos1) begin
      region_c = REGION_START;
    end else begin
      region_c = REGION_END;
    end
  end

  logic               s3_valid;
  psd_region_t        s3_region;
  logic [DEN_W-1:0]   s3_len2;
  logic [QUO_W-1:0]   s3_sel;
  logic [CROSS_W-1:0] s3_c [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_region <= region_c;
      s3_len2   <= len2_s[DEN_W-1:0];
      s3_sel    <= (region_c == REGION_END) ? ww_s[QUO_W-1:0] : vv_s[QUO_W-1:0];
      s3_c      <= cmag;
    end
  end

  // stage 4: partial products of each cross magnitude (high 32, low 33 bits)
  localparam int LO_W = 33;
  localparam int HI_W = CROSS_W - LO_W;

  logic                 s4_valid;
  psd_region_t          s4_region;
  logic [DEN_W-1:0]     s4_len2;
  logic [QUO_W-1:0]     s4_sel;
  logic [2*HI_W-1:0]    s4_hh [3];
  logic [HI_W+LO_W-1:0] s4_hl [3];
  logic [2*LO_W-1:0]    s4_ll [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_hh[i] <= s3_c[i][CROSS_W-1:LO_W] * s3_c[i][CROSS_W-1:LO_W];
        s4_hl[i] <= s3_c[i][CROSS_W-1:LO_W] * s3_c[i][LO_W-1:0];
        s4_ll[i] <= s3_c[i][LO_W-1:0] * s3_c[i][LO_W-1:0];
      end
      s4_region <= s3_region;
      s4_len2   <= s3_len2;
      s4_sel    <= s3_sel;
    end
  end

  // stage 5: assemble the squares
  logic             s5_valid;
  psd_region_t      s5_region;
  logic [DEN_W-1:0] s5_len2;
  logic [QUO_W-1:0] s5_sel;
  logic [SQ_W-1:0]  s5_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else if (en) begin
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_sq[i] <= (SQ_W'(s4_hh[i]) << (2*LO_W)) + (SQ_W'(s4_hl[i]) << (LO_W+1))
                  + SQ_W'(s4_ll[i]);
      end
      s5_region <= s4_region;
      s5_len2   <= s4_len2;
      s5_sel    <= s4_sel;
    end
  end

  // stage 6: pick dividend and divisor
  logic [NUM_W-1:0] n2;

  assign n2 = NUM_W'(s5_sq[0]) + NUM_W'(s5_sq[1]) + NUM_W'(s5_sq[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s5_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frac.region <= s5_region;
      if (s5_region == REGION_INTERIOR) begin
        frac.num <= n2;
        frac.den <= s5_len2;
      end else begin
        frac.num <= NUM_W'(s5_sel);
        frac.den <= DEN_W'(1);
      end
    end
  end

endmodule

[src/psd_div.sv]
module psd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  psd_pkg::psd_frac_t frac,
  output logic               out_valid,
  output psd_pkg::psd_quo_t  quo
);
  import psd_pkg::*;

  logic             valid  [DIV_STEPS+1];
  logic [DEN_W-1:0] rem    [DIV_STEPS+1];
  logic [QUO_W-1:0] lo     [DIV_STEPS+1];
  logic [DEN_W-1:0] den    [DIV_STEPS+1];
  psd_region_t      region [DIV_STEPS+1];

  // upper dividend half is already below the divisor
  assign valid[0]  = in_valid;
  assign rem[0]    = frac.num[NUM_W-1:QUO_W];
  assign lo[0]     = frac.num[QUO_W-1:0];
  assign den[0]    = frac.den;
  assign region[0] = frac.region;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {rem[k], lo[k][QUO_W-1]};
    assign diff  = trial - {1'b0, den[k]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        lo[k+1]     <= {lo[k][QUO_W-2:0], ge};
        den[k+1]    <= den[k];
        region[k+1] <= region[k];
      end
    end
  end

  assign out_valid  = valid[DIV_STEPS];
  assign quo.quo    = lo[DIV_STEPS];
  assign quo.region = region[DIV_STEPS];

endmodule

[src/psd_sqrt.sv]
module psd_sqrt (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  psd_pkg::psd_quo_t quo,
  output logic              out_valid,
  output psd_pkg::psd_rsp_t rsp
);
  import psd_pkg::*;

  logic              valid  [SQRT_STEPS+1];
  logic [REM_W-1:0]  rem    [SQRT_STEPS+1];
  logic [ROOT_W-1:0] root   [SQRT_STEPS+1];
  logic [QUO_W-1:0]  x      [SQRT_STEPS+1];
  psd_region_t       region [SQRT_STEPS+1];

  assign valid[0]  = in_valid;
  assign rem[0]    = '0;
  assign root[0]   = '0;
  assign x[0]      = quo.quo;
  assign region[0] = quo.region;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    assign cur   = {rem[k], x[k][QUO_W-1:QUO_W-2]};
    assign trial = (REM_W+2)'({root[k], 2'b01});
    assign diff  = cur - trial;
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k+1] <= 1'b0;
      end else if (en) begin
        valid[k+1] <= valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]    <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
        root[k+1]   <= {root[k][ROOT_W-2:0], ge};
        x[k+1]      <= {x[k][QUO_W-3:0], 2'b00};
        region[k+1] <= region[k];
      end
    end
  end

  assign out_valid    = valid[SQRT_STEPS];
  assign rsp.distance = DIST_W'(root[SQRT_STEPS]);
  assign rsp.region   = region[SQRT_STEPS];

endmodule

[src/point_segment_distance_3d.sv]
// Point to segment distance in 3D, signed Q16.16 coordinates.
// Request channel (req_valid/req_ready/req): query point and both segment
// endpoints. Response channel (rsp_valid/rsp_ready/rsp): floor of the
// Euclidean distance as unsigned Q18.16 plus a region code (degenerate
// segment, interior projection, nearest start, nearest end).
// Config channel (cfg_valid/cfg_ready/cfg_data): the degenerate length
// threshold, Q16.16; always ready, write it only while the block is idle.
// Throughput: one request per cycle while req_ready is high. A response
// passes through the front stages of differences, products and sums, a 66-stage restoring
// divider (one quotient bit per stage) and a 33-stage square root (one
// root bit per stage).
// Reset clears every valid bit and sets the threshold to 1 (one LSB).
// When the receiver stalls, the finished response moves into a skid
// register as the pipeline advances; then req_ready
// drops and the whole pipeline holds until the skid register drains.
module point_segment_distance_3d (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  psd_pkg::psd_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output psd_pkg::psd_rsp_t rsp,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import psd_pkg::*;

  logic        en;
  logic [31:0] deg_len;
  logic        frac_valid;
  psd_frac_t   frac;
  logic        quo_valid;
  psd_quo_t    quo;
  logic        last_valid;
  psd_rsp_t    last;
  logic        skid_full;
  psd_rsp_t    skid;

  // Threshold register; accept writes every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      deg_len <= 32'd1;
    end else if (cfg_valid) begin
      deg_len <= cfg_data;
    end
  end

  // Advance the whole pipeline whenever the skid register is free.
  assign en        = ~skid_full;
  assign req_ready = ~skid_full;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req_valid),
    .req       (req),
    .deg_len   (deg_len),
    .out_valid (frac_valid),
    .frac      (frac)
  );

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (frac_valid),
    .frac      (frac),
    .out_valid (quo_valid),
    .quo       (quo)
  );

  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (quo_valid),
    .quo       (quo),
    .out_valid (last_valid),
    .rsp       (last)
  );

  // Skid: catch the last stage when the receiver holds off, drain when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (rsp_ready) begin
        skid_full <= 1'b0;
      end
    end else if (last_valid && !rsp_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid <= last;
    end
  end

  // Present the skid entry first; it is always the older response.
  assign rsp_valid = skid_full | last_valid;
  assign rsp       = skid_full ? skid : last;

endmodule

[sim/psd_checker.sv]
module psd_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_ready,
  input  psd_pkg::psd_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_ready,
  input  psd_pkg::psd_rsp_t rsp,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [31:0]       cfg_data,
  output int                errors,
  output int                outstanding
);
  import psd_pkg::*;

  typedef logic signed [255:0] big_t;

  logic [31:0] threshold;
  psd_rsp_t    distance_fifo[$];

  function automatic big_t dot(big_t x0, big_t x1, big_t x2, big_t y0, big_t y1, big_t y2);
    return x0 * y0 + x1 * y1 + x2 * y2;
  endfunction

  // floor(sqrt(num / den)) by one root bit per pass
  function automatic logic [DIST_W-1:0] floor_root(big_t num, big_t den);
    big_t root;
    big_t cand;
    root = '0;
    for (int bit_i = DIST_W - 1; bit_i >= 0; bit_i--) begin
      cand = root | (big_t'(1) <<< bit_i);
      if (cand * cand * den <= num) root = cand;
    end
    return root[DIST_W-1:0];
  endfunction

  function automatic psd_rsp_t segment_distance(psd_req_t r, logic [31:0] thr);
    big_t d0, d1, d2, v0, v1, v2, w0, w1, w2;
    big_t len2, thr2, dot_start, dot_end, c0, c1, c2;
    psd_rsp_t res;
    d0 = big_t'(r.end_x) - big_t'(r.start_x);
    d1 = big_t'(r.end_y) - big_t'(r.start_y);
    d2 = big_t'(r.end_z) - big_t'(r.start_z);
    v0 = big_t'(r.query_x) - big_t'(r.start_x);
    v1 = big_t'(r.query_y) - big_t'(r.start_y);
    v2 = big_t'(r.query_z) - big_t'(r.start_z);
    w0 = big_t'(r.query_x) - big_t'(r.end_x);
    w1 = big_t'(r.query_y) - big_t'(r.end_y);
    w2 = big_t'(r.query_z) - big_t'(r.end_z);
    len2 = dot(d0, d1, d2, d0, d1, d2);
    thr2 = big_t'({224'b0, thr}) * big_t'({224'b0, thr});
    if (len2 < thr2) begin
      res.region   = REGION_DEGEN;
      res.distance = floor_root(dot(v0, v1, v2, v0, v1, v2), 1);
    end else begin
      dot_start = dot(d0, d1, d2, v0, v1, v2);
      dot_end   = -dot(d0, d1, d2, w0, w1, w2);
      if (dot_start > 0 && dot_end > 0) begin
        c0 = d1 * v2 - d2 * v1;
        c1 = d2 * v0 - d0 * v2;
        c2 = d0 * v1 - d1 * v0;
        res.region   = REGION_INTERIOR;
        res.distance = floor_root(dot(c0, c1, c2, c0, c1, c2), len2);
      end else if (dot_start <= 0) begin
        res.region   = REGION_START;
        res.distance = floor_root(dot(v0, v1, v2, v0, v1, v2), 1);
      end else begin
        res.region   = REGION_END;
        res.distance = floor_root(dot(w0, w1, w2, w0, w1, w2), 1);
      end
    end
    return res;
  endfunction

  assign outstanding = distance_fifo.size();

  always @(posedge clk) begin
    psd_rsp_t exp_rsp;
    int       fails;
    fails = 0;
    if (rst) begin
      threshold <= 32'd1;
      errors    <= 0;
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      if (req_valid && req_ready) distance_fifo.push_back(segment_distance(req, threshold));
      if (rsp_valid && rsp_ready) begin
        if (distance_fifo.size() == 0) begin
          $error("response with no request pending: distance %0d region %0d",
                 rsp.distance, rsp.region);
          fails++;
        end else begin
          exp_rsp = distance_fifo.pop_front();
          if (rsp.distance !== exp_rsp.distance) begin
            $error("distance: expected %0d actual %0d", exp_rsp.distance, rsp.distance);
            fails++;
          end
          if (rsp.region !== exp_rsp.region) begin
            $error("region: expected %0d actual %0d", exp_rsp.region, rsp.region);
            fails++;
          end
        end
      end
      errors <= errors + fails;
    end
  end
endmodule

[sim/point_segment_distance_3d_tb.sv]
module point_segment_distance_3d_tb;
  import psd_pkg::*;

  localparam int LATENCY  = 105;
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  psd_req_t    req = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  psd_rsp_t    rsp;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  int          errors;
  int          outstanding;
  int          quiet_cycles = 0;
  int          rsp_stall = 0;
  logic        rsp_taken = 1'b0;
  bit          no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_segment_distance_3d dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  psd_checker u_checker (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  // Abort if no channel moves anything for too long.
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Note each accepted response so the receiver can draw its next stall.
  always @(posedge clk) begin
    rsp_taken <= !rst && rsp_valid && rsp_ready;
  end

  // Receiver: after most responses (never under no_idle), hold ready low for a random count.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (rsp_taken && !no_idle && rsp_stall == 0 && $urandom_range(0, 3) != 0) begin
      rsp_stall <= $urandom_range(0, 9);
      rsp_ready <= 1'b0;
    end else if (rsp_stall > 0) begin
      rsp_stall <= rsp_stall - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  task automatic send_request(input psd_req_t item);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    repeat (gap) @(negedge clk);
    req_valid = 1'b1;
    req = item;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  // Write the threshold only once every request has come back.
  task automatic write_threshold(input logic [31:0] value);
    while (outstanding != 0) @(negedge clk);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [31:0] near_coord(input logic signed [31:0] base, int span);
    return base + $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic psd_req_t random_request();
    psd_req_t item;
    int mode;
    int span;
    mode = $urandom_range(0, 9);
    item = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom};
    case (mode)
      0, 1: begin
        // full-range coordinates, already drawn
      end
      2, 3, 4: begin
        // modest coordinates so interior and endpoint cases all show up
        span = 1 << $urandom_range(4, 24);
        item.query_x = near_coord(0, span);
        item.query_y = near_coord(0, span);
        item.query_z = near_coord(0, span);
        item.start_x = near_coord(0, span);
        item.start_y = near_coord(0, span);
        item.start_z = near_coord(0, span);
        item.end_x   = near_coord(0, span);
        item.end_y   = near_coord(0, span);
        item.end_z   = near_coord(0, span);
      end
      5, 6: begin
        // very short segments, around the degenerate threshold
        span = $urandom_range(0, 3) == 0 ? 3 : (1 << $urandom_range(0, 18));
        item.end_x = near_coord(item.start_x, span);
        item.end_y = near_coord(item.start_y, span);
        item.end_z = near_coord(item.start_z, span);
      end
      7: begin
        // query on or near an endpoint
        if ($urandom_range(0, 1)) begin
          item.query_x = near_coord(item.start_x, 2);
          item.query_y = near_coord(item.start_y, 2);
          item.query_z = near_coord(item.start_z, 2);
        end else begin
          item.query_x = near_coord(item.end_x, 2);
          item.query_y = near_coord(item.end_y, 2);
          item.query_z = near_coord(item.end_z, 2);
        end
      end
      default: begin
        // axis-aligned segment with query beside it
        item.start_y = item.end_y;
        item.start_z = item.end_z;
        item.query_x = item.start_x / 2 + item.end_x / 2;
      end
    endcase
    return item;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) no_idle = ($urandom_range(0, 4) == 0);
      send_request(random_request());
    end
    no_idle = 1'b0;
  endtask

  function automatic psd_req_t make_request(
      input logic signed [31:0] qx, qy, qz, sx, sy, sz, ex, ey, ez);
    psd_req_t item;
    item.query_x = qx; item.query_y = qy; item.query_z = qz;
    item.start_x = sx; item.start_y = sy; item.start_z = sz;
    item.end_x   = ex; item.end_y   = ey; item.end_z   = ez;
    return item;
  endfunction

  localparam logic signed [31:0] MAXC = 32'sh7fffffff;
  localparam logic signed [31:0] MINC = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed requests under the reset threshold.
    send_request(make_request(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_request(make_request(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC));
    send_request(make_request(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MINC, MINC));
    send_request(make_request(MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC, MAXC, MINC));
    send_request(make_request(0, 0, MAXC, MINC, 0, 0, MAXC, 0, 0));
    send_request(make_request(0, ONE, 0, -ONE, 0, 0, ONE, 0, 0));
    send_request(make_request(3, 5, 7, 0, 0, 0, 10, 0, 0));
    send_request(make_request(-ONE, ONE, 0, 0, 0, 0, ONE, 0, 0));
    send_request(make_request(2 * ONE, ONE, 0, 0, 0, 0, ONE, 0, 0));
    send_request(make_request(0, 0, 0, 0, 0, 0, ONE, 0, 0));
    send_request(make_request(ONE, 0, 0, 0, 0, 0, ONE, 0, 0));
    send_request(make_request(ONE, ONE, ONE, 5, 5, 5, 5, 5, 5));
    send_request(make_request(ONE, 2, 0, 0, 0, 0, 3 * ONE, 0, 0));
    send_request(make_request(0, 0, 0, 0, 0, 0, 0, 0, 1));
    run_random(300);

    // Zero threshold: zero-length segments are not degenerate.
    write_threshold(32'd0);
    send_request(make_request(ONE, ONE, ONE, 7, 7, 7, 7, 7, 7));
    send_request(make_request(MINC, MAXC, 0, 0, 0, 0, 0, 0, 0));
    run_random(250);

    // Largest threshold: nearly every segment collapses onto its start.
    write_threshold(32'hffffffff);
    send_request(make_request(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MAXC, MAXC));
    send_request(make_request(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    run_random(250);

    write_threshold(32'h00010000);
    send_request(make_request(0, 0, 0, 0, 0, 0, ONE - 1, 0, 0));
    send_request(make_request(0, 0, 0, 0, 0, 0, ONE, 0, 0));
    run_random(250);

    write_threshold($urandom);
    run_random(150);

    write_threshold(32'd3);
    run_random(150);

    while (outstanding != 0) @(negedge clk);
    repeat (LATENCY + 20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
